@@ src/cpu_load_store_unit_defines.svh @@
// Assertion macros used by the checker file of the load/store unit.
`ifndef CPU_LOAD_STORE_UNIT_DEFINES_SVH
`define CPU_LOAD_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cpu_lsu_pkg.sv @@
package cpu_lsu_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    KIND_LDAA = 3'd0,
    KIND_LDAB = 3'd1,
    KIND_LDS  = 3'd2,
    KIND_LDX  = 3'd3,
    KIND_STAA = 3'd4,
    KIND_STAB = 3'd5,
    KIND_STX  = 3'd6,
    KIND_STS  = 3'd7
  } kind_e;

  // Addressing modes
  typedef enum logic [1:0] {
    MODE_IMM = 2'd0,
    MODE_DIR = 2'd1,
    MODE_EXT = 2'd2,
    MODE_IDX = 2'd3
  } mode_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming instruction
    logic mem_rd;   // issue a memory read
    logic mem_wr;   // issue a memory write
    logic addr_lo;  // address the second byte (ea + 1)
    logic wr_lo;    // write data is the low byte of a word
    logic cap_hi;   // capture read data as high byte
    logic cap_lo;   // capture read data as low byte
    logic finish;   // retire: update registers, flags and result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic legal;
    logic is_store;
    logic wide;
    logic imm;
  } stat_t;

endpackage

@@ src/cpu_lsu_ram.sv @@
module cpu_lsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/cpu_lsu_ctrl.sv @@
module cpu_lsu_ctrl
  import cpu_lsu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_RDH  = 6'b000100,
    S_RDL  = 6'b001000,
    S_WRL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat_i.legal || (!stat_i.is_store && stat_i.imm)) begin
          state_d = S_FIN;
        end else if (stat_i.is_store) begin
          cmd_o.mem_wr = 1'b1;
          state_d      = stat_i.wide ? S_WRL : S_FIN;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = stat_i.wide ? S_RDH : S_RDL;
        end
      end
      S_RDH: begin
        cmd_o.cap_hi  = 1'b1;
        cmd_o.mem_rd  = 1'b1;
        cmd_o.addr_lo = 1'b1;
        state_d       = S_RDL;
      end
      S_RDL: begin
        cmd_o.cap_lo = 1'b1;
        state_d      = S_FIN;
      end
      S_WRL: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.addr_lo = 1'b1;
        cmd_o.wr_lo   = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid
  assign out_valid_d = cmd_o.finish || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/cpu_lsu_dp.sv @@
module cpu_lsu_dp
  import cpu_lsu_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic [2:0]           kind_i,
  input  logic [1:0]           mode_i,
  input  logic [15:0]          operand_i,
  output logic                 mem_we_o,
  output logic                 mem_re_o,
  output logic [ADDR_BITS-1:0] mem_addr_o,
  output logic [7:0]           mem_wdata_o,
  input  logic [7:0]           mem_rdata_i,
  output logic [7:0]           acc_a_o,
  output logic [7:0]           acc_b_o,
  output logic [15:0]          index_x_o,
  output logic [15:0]          stack_ptr_o,
  output logic                 flag_n_o,
  output logic                 flag_z_o,
  output logic                 flag_v_o,
  output logic                 legal_o,
  output logic [15:0]          eff_addr_o,
  output logic                 did_write_o
);

  // Architectural state
  logic [7:0]  reg_a_q, reg_a_d;
  logic [7:0]  reg_b_q, reg_b_d;
  logic [15:0] reg_x_q, reg_x_d;
  logic [15:0] reg_sp_q, reg_sp_d;
  logic        flag_n_q, flag_n_d;
  logic        flag_z_q, flag_z_d;
  logic        flag_v_q, flag_v_d;

  // Instruction in flight
  kind_e       kind_q;
  mode_e       mode_q;
  logic [15:0] opnd_q;
  logic [15:0] ea_q, ea_d;
  logic        legal_q, legal_d;
  logic [7:0]  hi_q;
  logic [7:0]  lo_q;

  // Result register
  logic [7:0]  out_a_q, out_b_q;
  logic [15:0] out_x_q, out_sp_q, out_ea_q;
  logic        out_n_q, out_z_q, out_v_q, out_legal_q, out_wr_q;

  logic        is_store, wide;
  logic [15:0] st_val, ld_val, val;
  logic [15:0] mem_addr16;

  // Legality and effective address of the incoming instruction
  always_comb begin
    legal_d = !(kind_i[2] && (mode_e'(mode_i) == MODE_IMM));
    case (mode_e'(mode_i))
      MODE_DIR: ea_d = {8'h00, operand_i[7:0]};
      MODE_EXT: ea_d = operand_i;
      MODE_IDX: ea_d = reg_x_q + {8'h00, operand_i[7:0]};
      default:  ea_d = '0;
    endcase
    if (!legal_d) begin
      ea_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_e'(kind_i);
      mode_q  <= mode_e'(mode_i);
      opnd_q  <= operand_i;
      ea_q    <= ea_d;
      legal_q <= legal_d;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= mem_rdata_i;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= mem_rdata_i;
    end
  end

  assign is_store = kind_q[2];
  assign wide     = kind_q[1];

  assign stat_o.legal    = legal_q;
  assign stat_o.is_store = is_store;
  assign stat_o.wide     = wide;
  assign stat_o.imm      = (mode_q == MODE_IMM);

  // Store source
  always_comb begin
    case (kind_q)
      KIND_STAA: st_val = {8'h00, reg_a_q};
      KIND_STAB: st_val = {8'h00, reg_b_q};
      KIND_STX:  st_val = reg_x_q;
      default:   st_val = reg_sp_q;
    endcase
  end

  // Memory port: big-endian words, second byte at ea + 1
  assign mem_addr16  = cmd_i.addr_lo ? (ea_q + 16'd1) : ea_q;
  assign mem_addr_o  = mem_addr16[ADDR_BITS-1:0];
  assign mem_we_o    = cmd_i.mem_wr;
  assign mem_re_o    = cmd_i.mem_rd;
  assign mem_wdata_o = (wide && !cmd_i.wr_lo) ? st_val[15:8] : st_val[7:0];

  // Loaded value
  always_comb begin
    if (mode_q == MODE_IMM) begin
      ld_val = wide ? opnd_q : {8'h00, opnd_q[7:0]};
    end else begin
      ld_val = wide ? {hi_q, lo_q} : {8'h00, lo_q};
    end
  end

  assign val = is_store ? st_val : ld_val;

  // Retire: register and flag updates
  always_comb begin
    reg_a_d  = reg_a_q;
    reg_b_d  = reg_b_q;
    reg_x_d  = reg_x_q;
    reg_sp_d = reg_sp_q;
    flag_n_d = flag_n_q;
    flag_z_d = flag_z_q;
    flag_v_d = flag_v_q;
    if (legal_q) begin
      if (!is_store) begin
        case (kind_q)
          KIND_LDAA: reg_a_d  = ld_val[7:0];
          KIND_LDAB: reg_b_d  = ld_val[7:0];
          KIND_LDS:  reg_sp_d = ld_val;
          default:   reg_x_d  = ld_val;
        endcase
      end
      flag_n_d = wide ? val[15] : val[7];
      flag_z_d = (val == 16'h0000);
      flag_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_a_q  <= '0;
      reg_b_q  <= '0;
      reg_x_q  <= '0;
      reg_sp_q <= '0;
      flag_n_q <= 1'b0;
      flag_z_q <= 1'b0;
      flag_v_q <= 1'b0;
    end else if (cmd_i.finish) begin
      reg_a_q  <= reg_a_d;
      reg_b_q  <= reg_b_d;
      reg_x_q  <= reg_x_d;
      reg_sp_q <= reg_sp_d;
      flag_n_q <= flag_n_d;
      flag_z_q <= flag_z_d;
      flag_v_q <= flag_v_d;
    end
  end

  // Result register, loaded at retire
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_a_q     <= reg_a_d;
      out_b_q     <= reg_b_d;
      out_x_q     <= reg_x_d;
      out_sp_q    <= reg_sp_d;
      out_n_q     <= flag_n_d;
      out_z_q     <= flag_z_d;
      out_v_q     <= flag_v_d;
      out_legal_q <= legal_q;
      out_ea_q    <= ea_q;
      out_wr_q    <= legal_q && is_store;
    end
  end

  assign acc_a_o     = out_a_q;
  assign acc_b_o     = out_b_q;
  assign index_x_o   = out_x_q;
  assign stack_ptr_o = out_sp_q;
  assign flag_n_o    = out_n_q;
  assign flag_z_o    = out_z_q;
  assign flag_v_o    = out_v_q;
  assign legal_o     = out_legal_q;
  assign eff_addr_o  = out_ea_q;
  assign did_write_o = out_wr_q;

endmodule

@@ src/cpu_load_store_unit.sv @@
// Load/store unit for an 8-bit processor of the 6800 family. One instruction
// (LDAA, LDAB, LDS, LDX, STAA, STAB, STX, STS in immediate, direct, extended
// or indexed mode) is taken at a time; the result transfer shows A, B, X, SP,
// N/Z/V, whether the mode was legal, the effective address and whether memory
// was written. Immediate loads, illegal stores and byte stores go from EXEC
// straight to FIN; byte loads pass RDL, word loads RDH and RDL, word stores
// WRL. The steps are set by the single byte-wide memory port with registered
// read: one byte access per cycle, and a word moves as two bytes, high byte
// first. A new instruction is taken in the cycle after the previous one
// retires, even while its result waits to be transferred out. Memory is
// 2^ADDR_BITS bytes, addressed by the low ADDR_BITS of the 16-bit address,
// not cleared at reset; reading a byte that was never written returns an
// unspecified value.
module cpu_load_store_unit
  import cpu_lsu_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  acc_a_o,
  output logic [7:0]  acc_b_o,
  output logic [15:0] index_x_o,
  output logic [15:0] stack_ptr_o,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        flag_v_o,
  output logic        legal_o,
  output logic [15:0] eff_addr_o,
  output logic        did_write_o
);

  cmd_t                 cmd;
  stat_t                stat;
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata, mem_rdata;

  cpu_lsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cpu_lsu_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (kind_i),
    .mode_i      (mode_i),
    .operand_i   (operand_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .acc_a_o     (acc_a_o),
    .acc_b_o     (acc_b_o),
    .index_x_o   (index_x_o),
    .stack_ptr_o (stack_ptr_o),
    .flag_n_o    (flag_n_o),
    .flag_z_o    (flag_z_o),
    .flag_v_o    (flag_v_o),
    .legal_o     (legal_o),
    .eff_addr_o  (eff_addr_o),
    .did_write_o (did_write_o)
  );

  cpu_lsu_ram #(
    .WIDTH (8),
    .DEPTH (1 << ADDR_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

@@ src/cpu_lsu_checker.sv @@
`include "cpu_load_store_unit_defines.svh"

module cpu_lsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  kind_i,
  input logic [1:0]  mode_i,
  input logic [15:0] operand_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  acc_a_o,
  input logic [7:0]  acc_b_o,
  input logic [15:0] index_x_o,
  input logic [15:0] stack_ptr_o,
  input logic        flag_n_o,
  input logic        flag_z_o,
  input logic        flag_v_o,
  input logic        legal_o,
  input logic [15:0] eff_addr_o,
  input logic        did_write_o
);

  // Illegal instructions leave memory alone and report no address
  `LSU_ASSERT_IMP(a_illegal_quiet, out_valid_o && !legal_o, !did_write_o && eff_addr_o == 16'h0000, "illegal instruction wrote memory or reported an address")

  // A memory write only comes from a legal store
  `LSU_ASSERT_IMP(a_write_legal, out_valid_o && did_write_o, legal_o && !flag_v_o, "write reported without a legal store")

  // One instruction in flight: no transfer in right after a transfer in
  `LSU_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "input ready right after a transfer in")

  // A stalled result holds
  `LSU_ASSERT_NXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(acc_a_o) && $stable(index_x_o) && $stable(eff_addr_o), "stalled result changed")

endmodule

bind cpu_load_store_unit cpu_lsu_checker u_checker (.*);
